FILE: design/ufpc_pkg.sv
`default_nettype none

package ufpc_pkg;

  // Widths of the result fields
  localparam int unsigned KindW  = 3;
  localparam int unsigned CmdW   = 8;
  localparam int unsigned BytesW = 7;
  localparam int unsigned ValueW = 16;

  // Result kinds reported in frame_kind
  localparam logic [KindW-1:0] KIND_LONG_OK  = 3'd0;
  localparam logic [KindW-1:0] KIND_LONG_BAD = 3'd1;
  localparam logic [KindW-1:0] KIND_SERVO    = 3'd2;
  localparam logic [KindW-1:0] KIND_STATUS   = 3'd3;
  localparam logic [KindW-1:0] KIND_SLEEP    = 3'd4;
  localparam logic [KindW-1:0] KIND_WAKE     = 3'd5;

  // One reported frame
  typedef struct packed {
    logic [ValueW-1:0] short_value;
    logic [BytesW-1:0] frame_bytes;
    logic [CmdW-1:0]   command_code;
    logic [KindW-1:0]  frame_kind;
  } result_t;

endpackage

`default_nettype wire

FILE: design/uart_frame_parser_crc8.sv
// Byte-stream frame parser. Each slave-side transfer carries one received byte. A long frame
// opens with 0xAA 0x55, carries a big-endian 16-bit length in bytes 2 and 3 and the command
// in byte 4, and ends after length+4 bytes; a reflected CRC-8 with polynomial 0x31 and a zero
// start value, taken over bytes 6 to length+1, is checked against byte length+2 and the
// outcome is reported as kind 0 (good) or 1 (bad). Short frames open with 0x01, 0x00, 0x02
// or 0x04, are four bytes long and are reported (kinds 2 to 5, with the 16-bit value of
// bytes 1 and 2) only if byte 3 is 0xFF. Frames that reach MAX_FRAME_BYTES without
// completing are dropped silently. The block takes one byte per clock cycle while no
// finished frame waits for the output register: a byte sits in an input register until
// the parser takes it, the parser state updates as it leaves, and any result lands in
// the output register, from which it is offered on the master side. Bytes that produce
// no result keep flowing while a result waits on the master side; only a byte that completes
// a frame waits for the output register.
`default_nettype none

module uart_frame_parser_crc8
  import ufpc_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Received bytes
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,  // [7:0] rx_byte
  // Frame results
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [39:0]      m_axis_tdata_o   // [2:0] frame_kind, [10:3] command_code,
                                            // [17:11] frame_bytes, [33:18] short_value,
                                            // [39:34] zero
);

  logic       in_valid;
  logic [7:0] in_byte;
  logic       res_valid;
  result_t    res;
  result_t    out_res;
  logic       out_free;
  logic       advance;

  // The byte in the input register moves on when it yields no result, or when the
  // output register can take its result in this cycle.
  assign advance = in_valid && (!res_valid || out_free);

  ufpc_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .data_i  (s_axis_tdata_i),
    .take_i  (advance),
    .valid_o (in_valid),
    .data_o  (in_byte)
  );

  ufpc_parser #(
    .MaxFrameBytes (MAX_FRAME_BYTES)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .byte_i      (in_byte),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  ufpc_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (advance && res_valid),
    .res_i   (res),
    .free_o  (out_free),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .res_o   (out_res)
  );

  assign m_axis_tdata_o = {6'd0, out_res};

endmodule

`default_nettype wire

FILE: design/ufpc_in_reg.sv
`default_nettype none

// Input register: holds one received byte until the parser takes it.
module ufpc_in_reg (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       valid_i,
  output logic            ready_o,
  input  wire logic [7:0] data_i,
  input  wire logic       take_i,
  output logic            valid_o,
  output logic [7:0]      data_o
);

  logic       valid_q, valid_d;
  logic [7:0] data_q;

  // A new byte may enter when the register is empty or being emptied.
  assign ready_o = !valid_q || take_i;
  assign valid_d = (valid_i && ready_o) ? 1'b1 : (take_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

FILE: design/ufpc_parser.sv
`default_nettype none

// Frame parser state and the per-byte step logic.
module ufpc_parser
  import ufpc_pkg::*;
#(
  parameter int unsigned MaxFrameBytes = 64
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic [7:0] byte_i,
  output logic            res_valid_o,
  output result_t         res_o
);

  localparam int unsigned CntW = $clog2(MaxFrameBytes + 1);

  localparam logic [7:0] START_LONG  = 8'hAA;
  localparam logic [7:0] SYNC_SECOND = 8'h55;
  localparam logic [7:0] SHORT_END   = 8'hFF;
  localparam logic [7:0] START_SERVO = 8'h01;
  localparam logic [7:0] START_STAT  = 8'h00;
  localparam logic [7:0] START_SLEEP = 8'h02;
  localparam logic [7:0] START_WAKE  = 8'h04;
  localparam logic [7:0] CRC_POLY    = 8'h8C;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_LONG   = 3'd1,
    MODE_SERVO  = 3'd2,
    MODE_STATUS = 3'd3,
    MODE_SLEEP  = 3'd4,
    MODE_WAKE   = 3'd5
  } mode_e;

  // One byte of reflected CRC-8 (polynomial 0x31 reflected).
  function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  mode_e             mode_q, mode_d;
  logic [CntW-1:0]   cnt_q, cnt_d, cnt_inc;
  logic [15:0]       len_q, len_d;
  logic [7:0]        crc_q, crc_d;
  logic [7:0]        rcrc_q, rcrc_d;
  logic [7:0]        cmd_q, cmd_d;
  logic [7:0]        hi_q, hi_d;
  logic [7:0]        lo_q, lo_d;
  logic [16:0]       len_p2, len_p4;
  logic              open;
  mode_e             open_mode;

  assign cnt_inc = cnt_q + CntW'(1);
  assign len_p2  = {1'b0, len_q} + 17'd2;
  assign len_p4  = {1'b0, len_q} + 17'd4;

  always_comb begin
    open      = 1'b1;
    open_mode = MODE_IDLE;
    unique case (byte_i)
      START_LONG:  open_mode = MODE_LONG;
      START_SERVO: open_mode = MODE_SERVO;
      START_STAT:  open_mode = MODE_STATUS;
      START_SLEEP: open_mode = MODE_SLEEP;
      START_WAKE:  open_mode = MODE_WAKE;
      default:     open = 1'b0;
    endcase
  end

  always_comb begin
    mode_d      = mode_q;
    cnt_d       = cnt_q;
    len_d       = len_q;
    crc_d       = crc_q;
    rcrc_d      = rcrc_q;
    cmd_d       = cmd_q;
    hi_d        = hi_q;
    lo_d        = lo_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    unique case (mode_q)
      MODE_IDLE: begin
        if (open) begin
          mode_d = open_mode;
          cnt_d  = CntW'(1);
          len_d  = '0;
          crc_d  = '0;
          rcrc_d = '0;
          cmd_d  = '0;
          hi_d   = '0;
          lo_d   = '0;
        end
      end
      MODE_LONG: begin
        cnt_d = cnt_inc;
        if (cnt_q == CntW'(1)) begin
          // A repeated start byte resynchronises; anything else drops the frame.
          if (byte_i != SYNC_SECOND) begin
            if (byte_i == START_LONG) begin
              cnt_d = CntW'(1);
            end else begin
              mode_d = MODE_IDLE;
            end
          end
        end else begin
          if (cnt_q == CntW'(2)) len_d = {byte_i, 8'h00};
          if (cnt_q == CntW'(3)) len_d = {len_q[15:8], byte_i};
          if (cnt_q == CntW'(4)) cmd_d = byte_i;
          if (cnt_q >= CntW'(6) && 17'(cnt_q) < len_p2) begin
            crc_d = crc_byte(crc_q, byte_i);
          end
          if (cnt_q >= CntW'(4) && 17'(cnt_q) == len_p2) begin
            rcrc_d = byte_i;
          end
          if (cnt_inc >= CntW'(6) && 17'(cnt_inc) == len_p4) begin
            res_valid_o        = 1'b1;
            res_o.frame_kind   = (crc_d == rcrc_d) ? KIND_LONG_OK : KIND_LONG_BAD;
            res_o.command_code = cmd_d;
            res_o.frame_bytes  = BytesW'(cnt_inc);
            mode_d             = MODE_IDLE;
          end
        end
        // Size limit: the frame is abandoned once the count reaches it.
        if (cnt_d >= CntW'(MaxFrameBytes)) mode_d = MODE_IDLE;
      end
      MODE_SERVO, MODE_STATUS, MODE_SLEEP, MODE_WAKE: begin
        cnt_d = cnt_inc;
        if (cnt_q == CntW'(1)) begin
          hi_d = byte_i;
        end else if (cnt_q == CntW'(2)) begin
          lo_d = byte_i;
        end else begin
          mode_d = MODE_IDLE;
          if (byte_i == SHORT_END) begin
            res_valid_o       = 1'b1;
            res_o.frame_bytes = BytesW'(4);
            res_o.short_value = {hi_q, lo_q};
            unique case (mode_q)
              MODE_SERVO:  res_o.frame_kind = KIND_SERVO;
              MODE_STATUS: res_o.frame_kind = KIND_STATUS;
              MODE_SLEEP:  res_o.frame_kind = KIND_SLEEP;
              default:     res_o.frame_kind = KIND_WAKE;
            endcase
          end
        end
      end
      default: begin
        mode_d = MODE_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      cnt_q  <= '0;
      len_q  <= '0;
      crc_q  <= '0;
      rcrc_q <= '0;
      cmd_q  <= '0;
      hi_q   <= '0;
      lo_q   <= '0;
    end else if (step_i) begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
      len_q  <= len_d;
      crc_q  <= crc_d;
      rcrc_q <= rcrc_d;
      cmd_q  <= cmd_d;
      hi_q   <= hi_d;
      lo_q   <= lo_d;
    end
  end

endmodule

`default_nettype wire

FILE: design/ufpc_out_reg.sv
`default_nettype none

// Result register on the master side.
module ufpc_out_reg
  import ufpc_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    load_i,
  input  wire result_t res_i,
  output logic         free_o,
  output logic         valid_o,
  input  wire logic    ready_i,
  output result_t      res_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_d = load_i ? 1'b1 : (ready_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

`default_nettype wire

FILE: tb/sv/ufpc_frame_checker.sv
package ufpc_tb_pkg;

  // Byte codes of the frame format
  localparam logic [7:0] SOF_LONG   = 8'hAA;
  localparam logic [7:0] SYNC_BYTE  = 8'h55;
  localparam logic [7:0] SHORT_END  = 8'hFF;
  localparam logic [7:0] SOF_SERVO  = 8'h01;
  localparam logic [7:0] SOF_STATUS = 8'h00;
  localparam logic [7:0] SOF_SLEEP  = 8'h02;
  localparam logic [7:0] SOF_WAKE   = 8'h04;

  // Polynomial 0x31 in reflected bit order.
  localparam logic [7:0] CRC_POLY_REV = 8'h8C;

  // One byte of the reflected CRC-8, least significant bit first.
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY_REV) : (c >> 1);
    end
    return c;
  endfunction

endpackage

module ufpc_frame_checker
  import ufpc_pkg::*;
  import ufpc_tb_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        rx_tvalid_i,
  input  logic        rx_tready_i,
  input  logic [7:0]  rx_tdata_i,
  input  logic        res_tvalid_i,
  input  logic        res_tready_i,
  input  logic [39:0] res_tdata_i,
  output int          pending_o,
  output int          mismatch_o
);

  typedef enum logic [1:0] {PARSE_IDLE, PARSE_LONG, PARSE_SHORT} parse_e;

  parse_e           mode;
  int unsigned      count;
  int unsigned      flen;
  logic [7:0]       crc_run;
  logic [7:0]       crc_rx;
  logic [7:0]       cmd;
  logic [7:0]       val_hi;
  logic [7:0]       val_lo;
  logic [KindW-1:0] short_kind;
  result_t          frames_due[$];

  function automatic void open_frame(input parse_e m, input logic [KindW-1:0] k);
    mode       = m;
    short_kind = k;
    count      = 1;
    flen       = 0;
    crc_run    = '0;
    crc_rx     = '0;
    cmd        = '0;
    val_hi     = '0;
    val_lo     = '0;
  endfunction

  // Advances the parser by one byte and queues the frame it completes, if any.
  function automatic void parse_byte(input logic [7:0] b);
    int unsigned pos;
    result_t     r;
    if (mode == PARSE_IDLE) begin
      case (b)
        SOF_LONG:   open_frame(PARSE_LONG, KIND_LONG_OK);
        SOF_SERVO:  open_frame(PARSE_SHORT, KIND_SERVO);
        SOF_STATUS: open_frame(PARSE_SHORT, KIND_STATUS);
        SOF_SLEEP:  open_frame(PARSE_SHORT, KIND_SLEEP);
        SOF_WAKE:   open_frame(PARSE_SHORT, KIND_WAKE);
        default: ;
      endcase
      return;
    end
    pos   = count;
    count = pos + 1;
    if (mode == PARSE_LONG) begin
      if (pos == 1) begin
        // A repeated start byte resynchronises; anything else but the sync byte drops out.
        if (b == SOF_LONG) begin
          count = 1;
        end else if (b != SYNC_BYTE) begin
          mode = PARSE_IDLE;
        end
      end else begin
        if (pos == 2) flen = {16'd0, b, 8'd0};
        if (pos == 3) flen = flen | b;
        if (pos == 4) cmd = b;
        if (pos >= 6 && pos < flen + 2) crc_run = crc8_step(crc_run, b);
        if (pos >= 4 && pos == flen + 2) crc_rx = b;
        if (count >= 6 && count == flen + 4) begin
          r.frame_kind   = (crc_run == crc_rx) ? KIND_LONG_OK : KIND_LONG_BAD;
          r.command_code = cmd;
          r.frame_bytes  = BytesW'(count);
          r.short_value  = '0;
          frames_due.push_back(r);
          mode = PARSE_IDLE;
        end
      end
      if (count >= MAX_FRAME_BYTES) mode = PARSE_IDLE;
    end else if (pos == 1) begin
      val_hi = b;
    end else if (pos == 2) begin
      val_lo = b;
    end else begin
      mode = PARSE_IDLE;
      if (b == SHORT_END) begin
        r.frame_kind   = short_kind;
        r.command_code = '0;
        r.frame_bytes  = BytesW'(4);
        r.short_value  = {val_hi, val_lo};
        frames_due.push_back(r);
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t got;
    result_t want;
    if (!rst_ni) begin
      mode  = PARSE_IDLE;
      count = 0;
      frames_due.delete();
      pending_o = 0;
    end else begin
      if (rx_tvalid_i && rx_tready_i) parse_byte(rx_tdata_i);
      if (res_tvalid_i && res_tready_i) begin
        got = result_t'(res_tdata_i[$bits(result_t)-1:0]);
        if (frames_due.size() == 0) begin
          mismatch_o++;
          if (mismatch_o <= 10) begin
            $display("%0t: frame reported with none due: kind %0d cmd %02h bytes %0d value %04h",
                     $time, got.frame_kind, got.command_code, got.frame_bytes,
                     got.short_value);
          end
        end else begin
          want = frames_due.pop_front();
          if (got.frame_kind !== want.frame_kind || got.command_code !== want.command_code ||
              got.frame_bytes !== want.frame_bytes || got.short_value !== want.short_value ||
              res_tdata_i[39:$bits(result_t)] !== '0) begin
            mismatch_o++;
            if (mismatch_o <= 10) begin
              $display("%0t: frame mismatch: expected kind %0d cmd %02h bytes %0d value %04h",
                       $time, want.frame_kind, want.command_code, want.frame_bytes,
                       want.short_value);
              $display("%0t:                 actual kind %0d cmd %02h bytes %0d value %04h pad %02h",
                       $time, got.frame_kind, got.command_code, got.frame_bytes,
                       got.short_value, res_tdata_i[39:$bits(result_t)]);
            end
          end
        end
      end
      pending_o = frames_due.size();
    end
  end

endmodule

FILE: tb/sv/uart_frame_parser_crc8_tb.sv
// Top of the frame parser testbench. It builds a byte stream, drives it into the parser
// with random gaps and reports the verdict; the checker beside the parser watches both
// channels, predicts each frame result and counts mismatches.
module uart_frame_parser_crc8_tb;
  import ufpc_pkg::*;
  import ufpc_tb_pkg::*;

  localparam int unsigned MaxFrame    = 64;
  localparam int unsigned RandomBytes = 650;
  // The receiver stops taking results for this many cycles once this many bytes have gone
  // in, so that a finished frame sits in the output register and the input backs up.
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned HoldAfter   = 320;

  logic        clk      = 1'b0;
  logic        rst_n    = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [7:0]  s_tdata  = 8'h00;
  logic        m_tready = 1'b0;
  logic        s_tready;
  logic        m_tvalid;
  logic [39:0] m_tdata;

  int          pending;
  int          mismatches;
  int unsigned sent = 0;
  logic [7:0]  stim_q[$];

  always #6 clk = ~clk;

  uart_frame_parser_crc8 #(
    .MAX_FRAME_BYTES(MaxFrame)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata)
  );

  ufpc_frame_checker #(
    .MAX_FRAME_BYTES(MaxFrame)
  ) chk (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .rx_tvalid_i (s_tvalid),
    .rx_tready_i (s_tready),
    .rx_tdata_i  (s_tdata),
    .res_tvalid_i(m_tvalid),
    .res_tready_i(m_tready),
    .res_tdata_i (m_tdata),
    .pending_o   (pending),
    .mismatch_o  (mismatches)
  );

  // Idle length between transfers: mostly none or short, now and then a long pause.
  function automatic int unsigned pick_gap(input bit quiet);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Length field of a long frame. Most lengths are small; some are zero or one and so can
  // never complete, some finish on or just before the size limit and some overrun it.
  function automatic int unsigned pick_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 6) return $urandom_range(0, 1);
    if (r < 12) return $urandom_range(MaxFrame - 7, MaxFrame - 4);
    if (r < 16) return $urandom_range(MaxFrame - 3, 65535);
    return $urandom_range(2, 16);
  endfunction

  task automatic add_short(input logic [7:0] sof, input logic [15:0] value,
                           input logic [7:0] tail);
    stim_q.push_back(sof);
    stim_q.push_back(value[15:8]);
    stim_q.push_back(value[7:0]);
    stim_q.push_back(tail);
  endtask

  // Queues a long frame with random content. The checksum byte is made to match when
  // crc_ok is set; keep cuts the frame short so that later bytes run on into it.
  task automatic add_long(input int unsigned flen, input bit crc_ok, input int unsigned keep);
    logic [7:0]  fr[MaxFrame];
    logic [7:0]  crc;
    int unsigned total;
    total = flen + 4;
    if (flen < 2 || total > MaxFrame) total = MaxFrame;
    foreach (fr[k]) fr[k] = 8'($urandom);
    fr[0] = SOF_LONG;
    fr[1] = SYNC_BYTE;
    fr[2] = flen[15:8];
    fr[3] = flen[7:0];
    if (flen >= 2 && flen + 4 <= MaxFrame) begin
      crc = 8'h00;
      for (int k = 6; k < flen + 2; k++) crc = crc8_step(crc, fr[k]);
      // With a length of two the checksum byte is also the command byte.
      if (crc_ok) fr[flen + 2] = crc;
    end
    if (keep < total) total = keep;
    for (int k = 0; k < total; k++) stim_q.push_back(fr[k]);
  endtask

  // Sender: builds the whole byte stream, then offers it one transfer at a time.
  initial begin
    int unsigned gap;
    int unsigned pick;
    int unsigned directed_len;
    logic [7:0]  sof;

    // Directed opening: every short kind, two with extreme values, a short frame whose end
    // byte is wrong, an ignored byte, a resynchronising double start byte followed by a
    // length-two frame whose checksum is its command byte, and a bad sync byte.
    add_short(SOF_SERVO, 16'hFFFF, SHORT_END);
    add_short(SOF_STATUS, 16'h0000, SHORT_END);
    add_short(SOF_SLEEP, 16'h1234, SHORT_END);
    add_short(SOF_WAKE, 16'h5678, 8'h00);
    stim_q.push_back(8'h33);
    stim_q.push_back(SOF_LONG);
    add_long(2, 1'b1, MaxFrame);
    stim_q.push_back(SOF_LONG);
    stim_q.push_back(8'h12);
    directed_len = stim_q.size();

    // Random part: mostly well-formed frames with random content, the rest noise and
    // broken or truncated frames.
    while (stim_q.size() < directed_len + RandomBytes) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        case ($urandom_range(0, 3))
          0:       sof = SOF_SERVO;
          1:       sof = SOF_STATUS;
          2:       sof = SOF_SLEEP;
          default: sof = SOF_WAKE;
        endcase
        add_short(sof, 16'($urandom), ($urandom_range(0, 4) != 0) ? SHORT_END : 8'($urandom));
      end else if (pick < 75) begin
        add_long(pick_length(), $urandom_range(0, 3) != 0, MaxFrame);
      end else if (pick < 88) begin
        repeat ($urandom_range(1, 4)) stim_q.push_back(8'($urandom));
      end else if (pick < 94) begin
        stim_q.push_back(SOF_LONG);
        stim_q.push_back(8'($urandom));
      end else begin
        add_long(pick_length(), 1'b1, $urandom_range(2, 8));
      end
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Every fourth stretch of eighty bytes is sent back to back.
    foreach (stim_q[i]) begin
      gap = pick_gap(((i / 80) % 4) == 1);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      s_tvalid <= 1'b1;
      s_tdata  <= stim_q[i];
      do @(posedge clk); while (!s_tready);
      sent++;
      @(negedge clk);
    end
    s_tvalid <= 1'b0;

    // Let the last results drain.
    wait (pending == 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Receiver: alternates bursts of readiness with stalls of random length, and once
  // holds off for a long stretch while the sender keeps offering bytes.
  initial begin
    int unsigned len;
    logic        lvl;
    bit          held;
    held = 1'b0;
    @(posedge rst_n);
    forever begin
      if (!held && sent >= HoldAfter) begin
        held = 1'b1;
        lvl  = 1'b0;
        len  = HoldCycles;
      end else if ($urandom_range(0, 9) < 6) begin
        lvl = 1'b1;
        len = $urandom_range(1, 24);
      end else begin
        lvl = 1'b0;
        len = pick_gap(1'b0) + 1;
      end
      @(negedge clk);
      m_tready <= lvl;
      repeat (len - 1) @(negedge clk);
    end
  end

  // Watchdog for a hung handshake or a result that never arrives.
  initial begin
    #(12 * 300000);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
